@@ rtl/core/kdp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdp_pkg
// Shared types, constants and the keypad decode for the keypad duty PWM unit.
// ----------------------------------------------------------------------------
package kdp_pkg;

    // Field widths.
    localparam int TOP_W   = 16;
    localparam int SCALE_W = 10;
    localparam int DUTY_W  = 7;
    localparam int CMP_W   = 17;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 16;

    // Operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_PWM_TOP       = 8'd0;
    localparam logic [IDX_W-1:0] CFG_COMPARE_SCALE = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [TOP_W-1:0]   PWM_TOP_RESET       = 16'd1000;
    localparam logic [SCALE_W-1:0] COMPARE_SCALE_RESET = 10'd10;

    // Duty limits and key codes.
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [3:0]        KEY_STAR  = 4'd12;

    typedef struct packed {
        logic       opcode;
        logic [1:0] key_row;
        logic [1:0] key_col;
    } kdp_in_t;

    typedef struct packed {
        logic              pwm_out;
        logic [DUTY_W-1:0] duty_percent;
        logic [DUTY_W-1:0] entry_value;
        logic              committed;
    } kdp_out_t;

    // Decoded key: whether it is a digit and which one.
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
    } kdp_key_t;

    // Keypad map 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
    function automatic kdp_key_t key_decode(input logic [3:0] idx);
        kdp_key_t k;
        k.is_digit = 1'b1;
        k.digit    = 4'd0;
        unique case (idx)
            4'd0:    k.digit = 4'd1;
            4'd1:    k.digit = 4'd2;
            4'd2:    k.digit = 4'd3;
            4'd4:    k.digit = 4'd4;
            4'd5:    k.digit = 4'd5;
            4'd6:    k.digit = 4'd6;
            4'd8:    k.digit = 4'd7;
            4'd9:    k.digit = 4'd8;
            4'd10:   k.digit = 4'd9;
            4'd13:   k.digit = 4'd0;
            default: k.is_digit = 1'b0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/core/keypad_duty_pwm_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_duty_pwm_unit
// PWM duty controller whose duty percent is typed in on a 4x4 keypad.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                         Direction  Moves
//  in       in_valid, in_ready, in_data     sink       tick or key press
//  out      out_valid, out_ready, out_data  source     PWM level and status
//  cfg      cfg_valid, cfg_ready, cfg_index sink       register write
//           cfg_data
//
//  One item per cycle: state and result are computed combinationally from the
//  accepted item and land in the output register at the accepting edge.
//  A new item is taken whenever the output register is empty or its result
//  is taken in the same cycle; a stalled output holds off the input only.
//  The configuration port is always ready. Reset clears the working state and
//  the output valid flag and loads the register defaults (top 1000, scale 10).
//
module keypad_duty_pwm_unit
    import kdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kdp_in_t             in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kdp_out_t            out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_data
);

    logic [TOP_W-1:0]   pwm_top_reg;
    logic [SCALE_W-1:0] compare_scale_reg;
    logic [TOP_W-1:0]   tick_count_reg, tick_count_next;
    logic [DUTY_W-1:0]  entry_accum_reg, entry_accum_next;
    logic [DUTY_W-1:0]  duty_store_reg, duty_store_next;
    logic [CMP_W-1:0]   compare_level_reg, compare_level_next;
    logic               out_valid_reg;
    kdp_out_t           out_data_reg, out_data_next;

    logic               in_xfer;
    logic [3:0]         key_idx;
    kdp_key_t           key;
    logic [10:0]        entry_times_ten;
    logic               commit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign key_idx = {in_data.key_row, in_data.key_col};
    assign key     = key_decode(key_idx);
    assign entry_times_ten = {4'd0, entry_accum_reg} * 11'd10 + {7'd0, key.digit};

    // Next state for one item.
    always_comb
    begin
        tick_count_next    = tick_count_reg;
        entry_accum_next   = entry_accum_reg;
        duty_store_next    = duty_store_reg;
        compare_level_next = compare_level_reg;
        commit             = 1'b0;
        if (in_data.opcode == OP_TICK)
        begin
            // Counter wraps to zero at or above top.
            if (tick_count_reg >= pwm_top_reg)
            begin
                tick_count_next = '0;
            end
            else
            begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
        else if (key_idx == KEY_STAR)
        begin
            // Commit the entry, full duty maps to one past top.
            commit           = 1'b1;
            entry_accum_next = '0;
            if (entry_accum_reg >= DUTY_FULL)
            begin
                duty_store_next    = DUTY_FULL;
                compare_level_next = {1'b0, pwm_top_reg} + 17'd1;
            end
            else
            begin
                duty_store_next    = entry_accum_reg;
                compare_level_next = CMP_W'({10'd0, entry_accum_reg}
                                            * {7'd0, compare_scale_reg});
            end
        end
        else if (key.is_digit)
        begin
            // Decimal entry saturating at full duty.
            if (entry_times_ten > {4'd0, DUTY_FULL})
            begin
                entry_accum_next = DUTY_FULL;
            end
            else
            begin
                entry_accum_next = entry_times_ten[DUTY_W-1:0];
            end
        end
    end

    // Result of the item.
    always_comb
    begin
        out_data_next.pwm_out      = ({1'b0, tick_count_next} < compare_level_next);
        out_data_next.duty_percent = duty_store_next;
        out_data_next.entry_value  = entry_accum_next;
        out_data_next.committed    = commit;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg       <= PWM_TOP_RESET;
            compare_scale_reg <= COMPARE_SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PWM_TOP)
            begin
                pwm_top_reg <= cfg_data[TOP_W-1:0];
            end
            else if (cfg_index == CFG_COMPARE_SCALE)
            begin
                compare_scale_reg <= cfg_data[SCALE_W-1:0];
            end
        end
    end

    // Working state, updated on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            entry_accum_reg   <= '0;
            duty_store_reg    <= '0;
            compare_level_reg <= '0;
        end
        else if (in_xfer)
        begin
            tick_count_reg    <= tick_count_next;
            entry_accum_reg   <= entry_accum_next;
            duty_store_reg    <= duty_store_next;
            compare_level_reg <= compare_level_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/core/kdp_checker.sv @@
// ----------------------------------------------------------------------------
// kdp_checker
// Port-level checks for the keypad duty PWM unit, bound to the top level.
// ----------------------------------------------------------------------------
module kdp_checker
    import kdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     out_valid,
    input  logic     out_ready,
    input  kdp_out_t out_data
);

    // A stalled result holds and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A commit always leaves the entry cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.committed |-> out_data.entry_value == '0)
        else $error("entry not cleared on commit");

    // Duty and entry never pass full duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty_percent <= DUTY_FULL
                      && out_data.entry_value <= DUTY_FULL)
        else $error("duty or entry above full");

    // Committing zero duty drives the output low.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.committed && out_data.duty_percent == '0
            |-> !out_data.pwm_out)
        else $error("zero duty drives output high");

endmodule

bind keypad_duty_pwm_unit kdp_checker u_kdp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
